/* src/vertex_transform_perspective_divide_defines.svh */
// Assertion macros used by the vertex transform back end.
// Depends on nothing; users supply signals named clock and reset.
`ifndef VERTEX_TRANSFORM_PERSPECTIVE_DIVIDE_DEFINES_SVH
`define VERTEX_TRANSFORM_PERSPECTIVE_DIVIDE_DEFINES_SVH

// Condition must hold at every edge out of reset.
`define VTPD_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Consequent must hold in the cycle of the antecedent.
`define VTPD_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VTPD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/vtpd_pkg.sv */
// Package for the vertex transform block: widths, constants, shared types.
// Depends on nothing.
`timescale 1ns / 1ps

package vtpd_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DW        = 32;
   localparam int NUM_REGS  = 8;
   localparam int REG_W     = 64;
   localparam int ADDR_W    = 4;
   localparam int NUM_W     = DW + FRAC_BITS;
   localparam int SUM_W     = 2 * DW + 2;
   localparam int MID_DEPTH = 4;
   localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);
   localparam int MID_PTR_W = $clog2(MID_DEPTH);

   localparam logic [DW-1:0] ONE_FX = DW'(1) << FRAC_BITS;

   // Register indexes
   localparam logic [ADDR_W-1:0] REG_ROW0_C01 = ADDR_W'(0);
   localparam logic [ADDR_W-1:0] REG_ROW0_C23 = ADDR_W'(1);
   localparam logic [ADDR_W-1:0] REG_ROW1_C01 = ADDR_W'(2);
   localparam logic [ADDR_W-1:0] REG_ROW1_C23 = ADDR_W'(3);
   localparam logic [ADDR_W-1:0] REG_ROW2_C01 = ADDR_W'(4);
   localparam logic [ADDR_W-1:0] REG_ROW2_C23 = ADDR_W'(5);
   localparam logic [ADDR_W-1:0] REG_ROW3_C01 = ADDR_W'(6);
   localparam logic [ADDR_W-1:0] REG_ROW3_C23 = ADDR_W'(7);

   // Identity matrix at reset
   function automatic logic [REG_W-1:0] cfg_reset(input int idx);
      logic [REG_W-1:0] v;
      v = '0;
      if (idx == int'(REG_ROW0_C01) || idx == int'(REG_ROW2_C23)) begin
         v = {{DW{1'b0}}, ONE_FX};
      end else if (idx == int'(REG_ROW1_C01) || idx == int'(REG_ROW3_C23)) begin
         v = {ONE_FX, {DW{1'b0}}};
      end
      return v;
   endfunction

   // Item between front and back: saturated rows plus classification
   typedef struct packed {
      logic [2:0][DW-1:0] xyz;
      logic [DW-1:0]      w;
      logic               div;
      logic               clip;
   } mid_item_type;

   typedef struct packed {
      logic empty;
      logic room;
   } mid_status_type;

endpackage

/* src/vertex_transform_perspective_divide.sv */
// Top level of the vertex transform with perspective divide.
// Depends on vtpd_pkg, vtpd_front, vtpd_queue, vtpd_back.
`timescale 1ns / 1ps

// Transforms one point (x, y, z, 1) per clock by a 4x4 Q16.16 matrix held in
// eight 64-bit registers and divides x, y, z by w when w is neither 0 nor 1.0.
// Throughput is one item per clock while neither stall below holds. On its way
// to the rsp_ ports an item passes 4 front stages, the middle queue, an entry
// stage, 32 + FRAC_BITS divider stages (one quotient bit each) and one fix-up
// stage. The front stalls only when the 4-entry middle queue is full, and the
// divider pipeline stalls only when the 2-entry result buffer holds two unread
// items. Write registers only while the block is drained.
module vertex_transform_perspective_divide (
   input  logic                            clock,
   input  logic                            reset,
   // configuration
   input  logic                            csr_we,
   input  logic [vtpd_pkg::ADDR_W-1:0]     csr_addr,
   input  logic [vtpd_pkg::REG_W-1:0]      csr_wdata,
   // item input
   input  logic                            push,
   output logic                            full,
   input  logic signed [vtpd_pkg::DW-1:0]  req_point_x,
   input  logic signed [vtpd_pkg::DW-1:0]  req_point_y,
   input  logic signed [vtpd_pkg::DW-1:0]  req_point_z,
   // results
   output logic                            empty,
   input  logic                            pop,
   output logic signed [vtpd_pkg::DW-1:0]  rsp_out_x,
   output logic signed [vtpd_pkg::DW-1:0]  rsp_out_y,
   output logic signed [vtpd_pkg::DW-1:0]  rsp_out_z,
   output logic                            rsp_did_divide,
   output logic                            rsp_clipped
);
   import vtpd_pkg::*;

   logic           front_adv;
   logic           mid_push;
   mid_item_type   mid_in;
   mid_item_type   mid_head;
   mid_status_type mid_stat;
   logic           back_adv;
   logic           mid_pop;

   // Front moves whenever the middle queue has a free slot
   assign front_adv = mid_stat.room;
   assign full      = !front_adv;
   // Back pulls an item whenever its pipeline advances and the queue holds one
   assign mid_pop   = back_adv && !mid_stat.empty;

   vtpd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .adv       (front_adv),
      .in_valid  (push),
      .point_x   (req_point_x),
      .point_y   (req_point_y),
      .point_z   (req_point_z),
      .out_valid (mid_push),
      .out_item  (mid_in)
   );

   vtpd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_item (mid_in),
      .pop       (mid_pop),
      .head      (mid_head),
      .status    (mid_stat)
   );

   vtpd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (mid_pop),
      .in_item    (mid_head),
      .adv        (back_adv),
      .pop        (pop),
      .empty      (empty),
      .out_x      (rsp_out_x),
      .out_y      (rsp_out_y),
      .out_z      (rsp_out_z),
      .did_divide (rsp_did_divide),
      .clipped    (rsp_clipped)
   );

endmodule

/* src/vtpd_front.sv */
// Front end: matrix registers, 4x4 multiply-accumulate pipeline, w classification.
// Depends on vtpd_pkg.
`timescale 1ns / 1ps

module vtpd_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [vtpd_pkg::ADDR_W-1:0]   csr_addr,
   input  logic [vtpd_pkg::REG_W-1:0]    csr_wdata,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic signed [vtpd_pkg::DW-1:0] point_x,
   input  logic signed [vtpd_pkg::DW-1:0] point_y,
   input  logic signed [vtpd_pkg::DW-1:0] point_z,
   output logic                          out_valid,
   output vtpd_pkg::mid_item_type        out_item
);
   import vtpd_pkg::*;

   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(2147483647);
   localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

   logic [REG_W-1:0] cfg_ff [NUM_REGS];

   logic signed [2*DW-1:0] prod_in [4][3];
   logic signed [2*DW-1:0] prod_ff [4][3];
   logic signed [DW-1:0]   tr_in [4];
   logic signed [DW-1:0]   tr_ff [4];
   logic                   v1_ff;

   logic signed [SUM_W-1:0] pa_in [4];
   logic signed [SUM_W-1:0] pb_in [4];
   logic signed [SUM_W-1:0] pa_ff [4];
   logic signed [SUM_W-1:0] pb_ff [4];
   logic                    v2_ff;

   logic signed [SUM_W-1:0] tot [4];
   logic signed [SUM_W-1:0] shr [4];
   logic [DW-1:0]           row_in [4];
   logic [3:0]              rclip;
   logic [DW-1:0]           row_ff [4];
   logic                    clip3_ff;
   logic                    v3_ff;

   mid_item_type item_in;
   mid_item_type item_ff;
   logic         v4_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_REGS; i++) begin
         if (reset) begin
            cfg_ff[i] <= cfg_reset(i);
         end else if (csr_we && csr_addr == ADDR_W'(i)) begin
            cfg_ff[i] <= csr_wdata;
         end
      end
   end

   // Stage 1: twelve products and the translation column
   always_comb begin
      logic signed [DW-1:0] pt [3];
      pt[0] = point_x;
      pt[1] = point_y;
      pt[2] = point_z;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[r][c] = pt[c] * $signed(cfg_ff[r*2 + c/2][(c%2)*DW +: DW]);
         end
         tr_in[r] = $signed(cfg_ff[r*2 + 1][DW +: DW]);
      end
   end

   // Stage 2: pairwise partial sums
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         pa_in[r] = {{2{prod_ff[r][0][2*DW-1]}}, prod_ff[r][0]}
                  + {{2{prod_ff[r][1][2*DW-1]}}, prod_ff[r][1]};
         pb_in[r] = {{2{prod_ff[r][2][2*DW-1]}}, prod_ff[r][2]}
                  + ({{(SUM_W-DW){tr_ff[r][DW-1]}}, tr_ff[r]} <<< FRAC_BITS);
      end
   end

   // Stage 3: full sum, floor shift, saturate
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         tot[r] = pa_ff[r] + pb_ff[r];
         shr[r] = tot[r] >>> FRAC_BITS;
         rclip[r] = 1'b0;
         if (shr[r] > SAT_HI) begin
            row_in[r] = SAT_HI[DW-1:0];
            rclip[r]  = 1'b1;
         end else if (shr[r] < SAT_LO) begin
            row_in[r] = SAT_LO[DW-1:0];
            rclip[r]  = 1'b1;
         end else begin
            row_in[r] = shr[r][DW-1:0];
         end
      end
   end

   // Stage 4: classify w
   always_comb begin
      item_in.xyz[0] = row_ff[0];
      item_in.xyz[1] = row_ff[1];
      item_in.xyz[2] = row_ff[2];
      item_in.w      = row_ff[3];
      item_in.div    = (row_ff[3] != '0) && (row_ff[3] != ONE_FX);
      item_in.clip   = clip3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff  <= prod_in;
         tr_ff    <= tr_in;
         pa_ff    <= pa_in;
         pb_ff    <= pb_in;
         row_ff   <= row_in;
         clip3_ff <= |rclip;
         item_ff  <= item_in;
      end
   end

   assign out_valid = v4_ff && adv;
   assign out_item  = item_ff;

endmodule

/* src/vtpd_queue.sv */
// Short queue of classified items between front and back end.
// Depends on vtpd_pkg.
`timescale 1ns / 1ps

module vtpd_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  vtpd_pkg::mid_item_type         push_item,
   input  logic                           pop,
   output vtpd_pkg::mid_item_type         head,
   output vtpd_pkg::mid_status_type       status
);
   import vtpd_pkg::*;

   mid_item_type          mem_ff [MID_DEPTH];
   logic [MID_PTR_W-1:0]  wr_ff, wr_in;
   logic [MID_PTR_W-1:0]  rd_ff, rd_in;
   logic [MID_CNT_W-1:0]  cnt_ff, cnt_in;

   always_comb begin
      wr_in  = push ? wr_ff + MID_PTR_W'(1) : wr_ff;
      rd_in  = pop  ? rd_ff + MID_PTR_W'(1) : rd_ff;
      cnt_in = cnt_ff + MID_CNT_W'(push) - MID_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

   assign head         = mem_ff[rd_ff];
   assign status.empty = (cnt_ff == '0);
   assign status.room  = (cnt_ff < MID_CNT_W'(MID_DEPTH));

endmodule

/* src/vtpd_back.sv */
// Back end: pipelined restoring divider (one quotient bit per stage),
// sign/saturation fix-up and a two-entry result buffer. Depends on vtpd_pkg.
`timescale 1ns / 1ps

module vtpd_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  vtpd_pkg::mid_item_type       in_item,
   output logic                         adv,
   input  logic                         pop,
   output logic                         empty,
   output logic signed [vtpd_pkg::DW-1:0] out_x,
   output logic signed [vtpd_pkg::DW-1:0] out_y,
   output logic signed [vtpd_pkg::DW-1:0] out_z,
   output logic                         did_divide,
   output logic                         clipped
);
   import vtpd_pkg::*;
   `include "vertex_transform_perspective_divide_defines.svh"

   localparam int OUT_DEPTH = 2;
   localparam logic [NUM_W-1:0] Q_HI = NUM_W'(2147483647);

   typedef struct packed {
      logic [DW-1:0]    rem;
      logic [NUM_W-1:0] nq;
      logic             neg;
   } lane_type;

   typedef struct packed {
      lane_type [2:0] lanes;
      logic [DW-1:0]  den;
      logic           div;
      logic           clip;
   } stage_type;

   typedef struct packed {
      logic [2:0][DW-1:0] xyz;
      logic               div;
      logic               clip;
   } result_type;

   function automatic lane_type div_step(input lane_type l, input logic [DW-1:0] den);
      logic [DW:0] trial;
      lane_type    o;
      trial = {l.rem, l.nq[NUM_W-1]};
      o.neg = l.neg;
      if (trial >= {1'b0, den}) begin
         o.rem = DW'(trial - {1'b0, den});
         o.nq  = {l.nq[NUM_W-2:0], 1'b1};
      end else begin
         o.rem = trial[DW-1:0];
         o.nq  = {l.nq[NUM_W-2:0], 1'b0};
      end
      return o;
   endfunction

   stage_type  stg_ff [NUM_W+1];
   logic       stv_ff [NUM_W+1];
   stage_type  entry_in;
   result_type fin_in, fin_ff;
   logic       finv_ff;

   result_type      ob_ff [OUT_DEPTH];
   logic            obw_ff, obr_ff;
   logic [1:0]      obc_ff;
   logic            ob_push, ob_pop;

   assign adv = (obc_ff < 2'(OUT_DEPTH));

   // Entry: magnitudes and signs; a lane that is not divided goes through 1.0
   always_comb begin
      logic          wneg;
      logic [DW-1:0] wmag;
      logic [DW-1:0] vmag;
      wneg = in_item.div && in_item.w[DW-1];
      wmag = in_item.w[DW-1] ? (~in_item.w + DW'(1)) : in_item.w;
      entry_in.den  = in_item.div ? wmag : ONE_FX;
      entry_in.div  = in_item.div;
      entry_in.clip = in_item.clip;
      for (int k = 0; k < 3; k++) begin
         vmag = in_item.xyz[k][DW-1] ? (~in_item.xyz[k] + DW'(1)) : in_item.xyz[k];
         entry_in.lanes[k].rem = '0;
         entry_in.lanes[k].nq  = {vmag, {FRAC_BITS{1'b0}}};
         entry_in.lanes[k].neg = in_item.xyz[k][DW-1] ^ wneg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stv_ff[0] <= 1'b0;
      end else if (adv) begin
         stv_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         stg_ff[0] <= entry_in;
      end
   end

   for (genvar s = 1; s <= NUM_W; s++) begin : g_div
      stage_type nxt;
      always_comb begin
         nxt = stg_ff[s-1];
         for (int k = 0; k < 3; k++) begin
            nxt.lanes[k] = div_step(stg_ff[s-1].lanes[k], stg_ff[s-1].den);
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            stv_ff[s] <= 1'b0;
         end else if (adv) begin
            stv_ff[s] <= stv_ff[s-1];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            stg_ff[s] <= nxt;
         end
      end
   end

   // Fix-up: apply sign, saturate the quotient to 32 bits
   always_comb begin
      logic [NUM_W-1:0] q;
      logic             c;
      c = stg_ff[NUM_W].clip;
      for (int k = 0; k < 3; k++) begin
         q = stg_ff[NUM_W].lanes[k].nq;
         if (stg_ff[NUM_W].lanes[k].neg) begin
            if (q > Q_HI + NUM_W'(1)) begin
               fin_in.xyz[k] = {1'b1, {(DW-1){1'b0}}};
               c = 1'b1;
            end else begin
               fin_in.xyz[k] = DW'(~q + NUM_W'(1));
            end
         end else begin
            if (q > Q_HI) begin
               fin_in.xyz[k] = {1'b0, {(DW-1){1'b1}}};
               c = 1'b1;
            end else begin
               fin_in.xyz[k] = q[DW-1:0];
            end
         end
      end
      fin_in.div  = stg_ff[NUM_W].div;
      fin_in.clip = c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         finv_ff <= 1'b0;
      end else if (adv) begin
         finv_ff <= stv_ff[NUM_W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fin_ff <= fin_in;
      end
   end

   // Result buffer
   assign ob_push = finv_ff && adv;
   assign ob_pop  = pop && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         obw_ff <= 1'b0;
         obr_ff <= 1'b0;
         obc_ff <= '0;
      end else begin
         if (ob_push) begin
            obw_ff <= ~obw_ff;
         end
         if (ob_pop) begin
            obr_ff <= ~obr_ff;
         end
         obc_ff <= obc_ff + 2'(ob_push) - 2'(ob_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (ob_push) begin
         ob_ff[obw_ff] <= fin_ff;
      end
   end

   assign empty      = (obc_ff == '0);
   assign out_x      = $signed(ob_ff[obr_ff].xyz[0]);
   assign out_y      = $signed(ob_ff[obr_ff].xyz[1]);
   assign out_z      = $signed(ob_ff[obr_ff].xyz[2]);
   assign did_divide = ob_ff[obr_ff].div;
   assign clipped    = ob_ff[obr_ff].clip;

   `VTPD_ASSERT_ALWAYS(a_ob_bound, obc_ff <= 2'(OUT_DEPTH), "result buffer overflow")
   `VTPD_ASSERT_IMPL(a_rem_lt_den, stv_ff[NUM_W],
      stg_ff[NUM_W].lanes[0].rem < stg_ff[NUM_W].den, "divider remainder not below divisor")
   `VTPD_ASSERT_IMPL(a_den_nz, stv_ff[0], stg_ff[0].den != '0, "zero divisor entered divider")
   `VTPD_ASSERT_NEXT(a_push_lands, ob_push && !ob_pop, !empty, "pushed result not visible")

endmodule
